// File: rtl/stalloc_pkg.sv
// Shared codes and fixed widths for the segment table allocator.
package stalloc_pkg;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ZERO   = 2'd3;

  // Fit policies.
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_NEXT  = 2'd1;
  localparam logic [1:0] POL_BEST  = 2'd2;
  localparam logic [1:0] POL_WORST = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] CFG_POLICY = 1'd0;
  localparam logic [0:0] CFG_ARENA  = 1'd1;

  // Field widths.
  localparam int CFG_DATA_W = 17;
  localparam int BYTES_W    = 16;
  localparam int COUNT_W    = 7;

endpackage

// File: rtl/segment_table_allocator_core.sv
// Top level of the segment table allocator: cell ring and command sequencer.
// Usage: a request carries cmd, req_bytes and free_offset on the in_ channel
// (valid/stall). Each request yields exactly one result on the out_ channel:
// status, block_offset and segment_count.
// The table lives in a ring of MAX_SEGMENTS cells that rotates by one slot per
// cycle while a request is searched or updated; the sequencer looks at the head
// cell and feeds the tail cell. An alloc takes one full rotation to search and
// a second to update the table. A free, or an alloc that finds no room, takes
// one rotation. Count, unused codes and zero-size allocs skip the ring and go
// straight to the result.
// One request is in work at a time; in_stall is high while it is.
// cfg_we writes policy (index 0) or arena_bytes (index 1); an arena write
// reloads the table at once. Write configuration only while idle.
// Reset (rst_n low, synchronous) gives first fit, a 65536-byte arena and a
// table of one free segment. A stalled result holds its output register;
// a finished request waits for it before the block accepts the next one.
module segment_table_allocator_core #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDR_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_cmd,
  input  logic [stalloc_pkg::BYTES_W-1:0]     in_req_bytes,
  input  logic [stalloc_pkg::BYTES_W-1:0]     in_free_offset,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic [stalloc_pkg::BYTES_W-1:0]     out_block_offset,
  output logic [stalloc_pkg::COUNT_W-1:0]     out_segment_count,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_addr,
  input  logic [stalloc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import stalloc_pkg::*;

  localparam int N  = MAX_SEGMENTS;
  localparam int AB = ADDR_BITS;
  localparam int SW = AB + 1;
  localparam int IW = $clog2(N);
  localparam int TW = $clog2(N + 1);
  localparam int CW = 34;
  localparam logic [SW-1:0] RST_SIZE =
    (AB >= 16) ? SW'(65536) : (SW'(1) << AB);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // Ring wiring: cell k takes from cell k+1, the last cell from the tail feed.
  logic          c_valid [N];
  logic          c_used  [N];
  logic [AB-1:0] c_off   [N];
  logic [SW-1:0] c_size  [N];
  logic          t_valid;
  logic          t_used;
  logic [AB-1:0] t_off;
  logic [SW-1:0] t_size;
  logic          ring_init;
  logic          ring_shift;
  logic [SW-1:0] init_size;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_tail
        stalloc_cell #(.ADDR_BITS(AB), .FIRST(g == 0)) u_cell (
          .clk(clk), .rst_n(rst_n), .init(ring_init), .init_size(init_size),
          .shift(ring_shift), .d_valid(t_valid), .d_used(t_used),
          .d_off(t_off), .d_size(t_size), .q_valid(c_valid[g]),
          .q_used(c_used[g]), .q_off(c_off[g]), .q_size(c_size[g]));
      end else begin : g_body
        stalloc_cell #(.ADDR_BITS(AB), .FIRST(g == 0)) u_cell (
          .clk(clk), .rst_n(rst_n), .init(ring_init), .init_size(init_size),
          .shift(ring_shift), .d_valid(c_valid[g+1]), .d_used(c_used[g+1]),
          .d_off(c_off[g+1]), .d_size(c_size[g+1]), .q_valid(c_valid[g]),
          .q_used(c_used[g]), .q_off(c_off[g]), .q_size(c_size[g]));
      end
    end
  endgenerate

  // Registers.
  logic [1:0]    state_r, state_nxt;
  logic [1:0]    policy_r;
  logic [TW-1:0] total_r;
  logic [IW-1:0] last_r;
  logic [IW-1:0] idx_r;
  logic [1:0]    cmd_r;
  logic [16:0]   need_r;
  logic [AB-1:0] foff_r;
  logic          found_r;
  logic [IW-1:0] pick_r;
  logic [SW-1:0] psize_r;
  logic [AB-1:0] poff_r;
  logic          lo_found_r;
  logic [IW-1:0] lo_pick_r;
  logic [SW-1:0] lo_size_r;
  logic [AB-1:0] lo_off_r;
  logic          split_r;
  logic          carry_v_r;
  logic          carry_u_r;
  logic [AB-1:0] carry_o_r;
  logic [SW-1:0] carry_s_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [BYTES_W-1:0] out_boff_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [1:0]    res_status_r;

  // Arena size from the configuration word: round up to 4, cap at 2^AB.
  logic [17:0] arena18;
  logic [CW-1:0] arena_ext;
  logic [CW-1:0] arena_lim;
  assign arena18   = ({1'b0, cfg_wdata} + 18'd3) & ~18'd3;
  assign arena_ext = CW'(arena18);
  assign arena_lim = CW'(1) << AB;
  assign init_size = !rst_n ? RST_SIZE :
                     SW'((arena_ext > arena_lim) ? arena_lim : arena_ext);
  assign ring_init = cfg_we && (cfg_addr == CFG_ARENA);

  // Head cell test.
  logic          fits;
  logic          last_idx;
  logic [IW-1:0] start;
  assign fits = c_valid[0] && !c_used[0] && (CW'(c_size[0]) >= CW'(need_r));
  assign last_idx = (idx_r == IW'(N - 1));
  assign start = (TW'(last_r) < total_r) ? last_r : '0;

  // On the last head test the head itself may still win the search.
  logic take_head;
  always_comb begin
    case (policy_r)
      POL_BEST:  take_head = fits && (!found_r || c_size[0] < psize_r);
      POL_WORST: take_head = fits && (!found_r || c_size[0] > psize_r);
      default:   take_head = fits && !found_r;
    endcase
  end

  // Final pick for every policy; next fit takes the first match at or after the start, else wraps.
  logic          f_found;
  logic [IW-1:0] f_pick;
  logic [SW-1:0] f_size;
  logic [AB-1:0] f_off;
  always_comb begin
    if (take_head) begin
      f_found = 1'b1;
      f_pick  = idx_r;
      f_size  = c_size[0];
      f_off   = c_off[0];
    end else if (policy_r == POL_NEXT && !found_r) begin
      f_found = lo_found_r;
      f_pick  = lo_pick_r;
      f_size  = lo_size_r;
      f_off   = lo_off_r;
    end else begin
      f_found = found_r;
      f_pick  = pick_r;
      f_size  = psize_r;
      f_off   = poff_r;
    end
  end

  logic [SW-1:0] left;
  assign left = f_size - SW'(need_r);

  logic accept;
  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign ring_shift = (state_r == S_SCAN) || (state_r == S_UPD);

  // Tail feed: plain rotation while searching, edits during the update pass.
  always_comb begin
    t_valid = c_valid[0];
    t_used  = c_used[0];
    t_off   = c_off[0];
    t_size  = c_size[0];
    if (state_r == S_UPD) begin
      if (cmd_r == CMD_FREE) begin
        if (c_valid[0] && c_off[0] == foff_r) t_used = 1'b0;
      end else if (idx_r == pick_r) begin
        t_used = 1'b1;
        t_size = SW'(need_r);
      end else if (carry_v_r) begin
        t_valid = 1'b1;
        t_used  = carry_u_r;
        t_off   = carry_o_r;
        t_size  = carry_s_r;
      end else if (split_r && idx_r > pick_r) begin
        t_valid = 1'b0;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ALLOC && in_req_bytes != '0) state_nxt = S_SCAN;
          else if (in_cmd == CMD_FREE) state_nxt = S_UPD;
          else state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (last_idx) begin
          if (f_found && !(left != '0 && total_r >= TW'(N))) state_nxt = S_UPD;
          else state_nxt = S_DONE;
        end
      end
      S_UPD: begin
        if (last_idx) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_FIRST;
      total_r     <= TW'(1);
      last_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_addr == CFG_POLICY) policy_r <= cfg_wdata[1:0];
      if (ring_init) begin
        total_r <= TW'(1);
        last_r  <= '0;
      end else if (state_r == S_UPD && last_idx && cmd_r == CMD_ALLOC) begin
        last_r <= pick_r;
        if (split_r) total_r <= total_r + TW'(1);
      end
      if (ring_shift) idx_r <= last_idx ? '0 : idx_r + IW'(1);
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Request fields, search results and the carried entry of a split.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_cmd;
      need_r     <= ({1'b0, in_req_bytes} + 17'd3) & ~17'd3;
      foff_r     <= AB'(32'(in_free_offset));
      found_r    <= 1'b0;
      lo_found_r <= 1'b0;
      carry_v_r  <= 1'b0;
      split_r    <= 1'b0;
      poff_r     <= '0;
      res_status_r <= (in_cmd == CMD_ALLOC && in_req_bytes == '0) ? ST_ZERO : ST_OK;
    end
    if (state_r == S_SCAN) begin
      if (fits && !last_idx) begin
        case (policy_r)
          POL_FIRST: begin
            if (!found_r) begin
              found_r <= 1'b1; pick_r <= idx_r; psize_r <= c_size[0];
              poff_r <= c_off[0];
            end
          end
          POL_NEXT: begin
            if (idx_r >= start) begin
              if (!found_r) begin
                found_r <= 1'b1; pick_r <= idx_r; psize_r <= c_size[0];
                poff_r <= c_off[0];
              end
            end else if (!lo_found_r) begin
              lo_found_r <= 1'b1; lo_pick_r <= idx_r; lo_size_r <= c_size[0];
              lo_off_r <= c_off[0];
            end
          end
          POL_BEST: begin
            if (!found_r || c_size[0] < psize_r) begin
              found_r <= 1'b1; pick_r <= idx_r; psize_r <= c_size[0];
              poff_r <= c_off[0];
            end
          end
          default: begin
            if (!found_r || c_size[0] > psize_r) begin
              found_r <= 1'b1; pick_r <= idx_r; psize_r <= c_size[0];
              poff_r <= c_off[0];
            end
          end
        endcase
      end
      if (last_idx) begin
        pick_r  <= f_pick;
        poff_r  <= f_off;
        split_r <= (left != '0);
        if (!f_found) res_status_r <= ST_NOFIT;
        else if (left != '0 && total_r >= TW'(N)) res_status_r <= ST_FULL;
      end
    end
    if (state_r == S_UPD && cmd_r == CMD_ALLOC && split_r) begin
      if (idx_r == pick_r) begin
        carry_v_r <= 1'b1;
        carry_u_r <= 1'b0;
        carry_o_r <= c_off[0] + AB'(need_r);
        carry_s_r <= c_size[0] - SW'(need_r);
      end else if (carry_v_r) begin
        carry_v_r <= c_valid[0];
        carry_u_r <= c_used[0];
        carry_o_r <= c_off[0];
        carry_s_r <= c_size[0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_status_r <= res_status_r;
      out_boff_r   <= (cmd_r == CMD_ALLOC && res_status_r == ST_OK) ?
                      BYTES_W'(32'(poff_r)) : '0;
      out_count_r  <= COUNT_W'(total_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_offset  = out_boff_r;
  assign out_segment_count = out_count_r;

endmodule

// File: rtl/stalloc_cell.sv
// One slot of the segment ring: offset, size, used and valid flags.
module stalloc_cell #(
  parameter int  ADDR_BITS = 16,
  parameter bit  FIRST     = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 init,
  input  logic [ADDR_BITS:0]   init_size,
  input  logic                 shift,
  input  logic                 d_valid,
  input  logic                 d_used,
  input  logic [ADDR_BITS-1:0] d_off,
  input  logic [ADDR_BITS:0]   d_size,
  output logic                 q_valid,
  output logic                 q_used,
  output logic [ADDR_BITS-1:0] q_off,
  output logic [ADDR_BITS:0]   q_size
);
  import stalloc_pkg::*;

  logic                 valid_r;
  logic                 used_r;
  logic [ADDR_BITS-1:0] off_r;
  logic [ADDR_BITS:0]   size_r;

  // Reset or arena reload leaves one free segment in the first slot only;
  // otherwise the slot takes its neighbor's contents on every shift.
  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      valid_r <= FIRST;
      used_r  <= 1'b0;
      off_r   <= '0;
      size_r  <= init_size;
    end else if (shift) begin
      valid_r <= d_valid;
      used_r  <= d_used;
      off_r   <= d_off;
      size_r  <= d_size;
    end
  end

  assign q_valid = valid_r;
  assign q_used  = used_r;
  assign q_off   = off_r;
  assign q_size  = size_r;

endmodule

// File: sim/tb.sv
// Self-checking testbench for segment_table_allocator_core.
module tb;
  import stalloc_pkg::*;

  localparam int NSEG = 64;
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [6:0]  count;
  } alloc_result_t;

  typedef struct {
    logic [1:0]    cmd;
    logic [15:0]   req;
    logic [15:0]   foff;
    bit            typed;
    alloc_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [15:0] in_req_bytes = '0;
  logic [15:0] in_free_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_block_offset;
  logic [6:0]  out_segment_count;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [16:0] cfg_wdata = '0;

  segment_table_allocator_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the segment table.
  logic [15:0] tbl_off [NSEG];
  logic [16:0] tbl_size [NSEG];
  bit          tbl_used [NSEG];
  int          tbl_total;
  int          last_pick;
  logic [1:0]  fit_policy;
  logic [16:0] arena_cfg;

  alloc_result_t pending_results[$];
  int  errors = 0;
  int  sent = 0;
  bit  quiet = 1'b0;
  bit  long_hold = 1'b0;

  function automatic void table_reload();
    logic [17:0] a;
    a = ({1'b0, arena_cfg} + 18'd3) & ~18'd3;
    if (a > 18'd65536) a = 18'd65536;
    for (int i = 0; i < NSEG; i++) begin
      tbl_off[i] = '0;
      tbl_size[i] = '0;
      tbl_used[i] = 1'b0;
    end
    tbl_size[0] = a[16:0];
    tbl_total = 1;
    last_pick = 0;
  endfunction

  function automatic bit seg_fits(int i, logic [16:0] need);
    return !tbl_used[i] && tbl_size[i] >= need;
  endfunction

  // Returns the segment picked by the current policy, or tbl_total if none fits.
  function automatic int pick_segment(logic [16:0] need);
    int pick;
    int j;
    pick = tbl_total;
    if (fit_policy == POL_NEXT) begin
      j = (last_pick < tbl_total) ? last_pick : 0;
      for (int i = 0; i < tbl_total; i++) begin
        if (seg_fits(j, need)) return j;
        j = (j + 1 == tbl_total) ? 0 : j + 1;
      end
      return tbl_total;
    end
    for (int i = 0; i < tbl_total; i++) begin
      if (!seg_fits(i, need)) continue;
      if (fit_policy == POL_FIRST) return i;
      if (pick == tbl_total ||
          (fit_policy == POL_BEST && tbl_size[i] < tbl_size[pick]) ||
          (fit_policy == POL_WORST && tbl_size[i] > tbl_size[pick]))
        pick = i;
    end
    return pick;
  endfunction

  // Applies one request to the shadow table and returns its result.
  function automatic alloc_result_t apply_request(logic [1:0] cmd, logic [15:0] req,
                                                  logic [15:0] foff);
    alloc_result_t r;
    logic [16:0] need;
    logic [16:0] left;
    int i;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      if (req == 0) begin
        r.status = ST_ZERO;
      end else begin
        need = ({1'b0, req} + 17'd3) & ~17'd3;
        i = pick_segment(need);
        if (i >= tbl_total) begin
          r.status = ST_NOFIT;
        end else begin
          left = tbl_size[i] - need;
          if (left != 0 && tbl_total >= NSEG) begin
            r.status = ST_FULL;
          end else begin
            if (left != 0) begin
              for (int k = tbl_total; k > i + 1; k--) begin
                tbl_off[k] = tbl_off[k-1];
                tbl_size[k] = tbl_size[k-1];
                tbl_used[k] = tbl_used[k-1];
              end
              tbl_off[i+1] = tbl_off[i] + need[15:0];
              tbl_size[i+1] = left;
              tbl_used[i+1] = 1'b0;
              tbl_total++;
            end
            tbl_used[i] = 1'b1;
            tbl_size[i] = need;
            last_pick = i;
            r.offset = tbl_off[i];
          end
        end
      end
    end else if (cmd == CMD_FREE) begin
      for (int k = 0; k < tbl_total; k++)
        if (tbl_off[k] == foff) tbl_used[k] = 1'b0;
    end
    r.count = tbl_total[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
  endtask

  // Result monitor.
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result count", 1, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_block_offset !== e.offset)
          report_mismatch("block_offset", out_block_offset, e.offset);
        if (out_segment_count !== e.count)
          report_mismatch("segment_count", out_segment_count, e.count);
      end
    end
  end

  // Receiver: random stalls, plus one long hold on request.
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      out_stall <= !quiet && ($urandom_range(99) < 11);
    end
  end

  // Offers one request; called and returning at a falling edge.
  task automatic send_request(logic [1:0] cmd, logic [15:0] req, logic [15:0] foff,
                              bit typed, alloc_result_t want);
    alloc_result_t r;
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_req_bytes <= req;
    in_free_offset <= foff;
    do @(posedge clk); while (in_stall);
    r = apply_request(cmd, req, foff);
    pending_results.push_back(typed ? want : r);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write, only issued once the block has drained.
  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) begin
      fit_policy = val[1:0];
    end else begin
      arena_cfg = val;
      table_reload();
    end
    @(negedge clk);
  endtask

  function automatic alloc_result_t mk(logic [1:0] s, logic [15:0] o, logic [6:0] c);
    alloc_result_t r;
    r.status = s;
    r.offset = o;
    r.count = c;
    return r;
  endfunction

  initial begin
    #40000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    logic [16:0] arena_choices[6];
    logic [1:0]  cmd;
    logic [15:0] req;
    logic [15:0] foff;
    int roll;
    int plen;
    int phase;

    fit_policy = POL_FIRST;
    arena_cfg = 17'd65536;
    table_reload();
    arena_choices = '{17'd65536, 17'd131071, 17'd1, 17'd0, 17'd4093, 17'd1024};

    // Directed requests from the reset state, first fit.
    rows.push_back('{CMD_COUNT, 16'd0,     16'd0,     1, mk(ST_OK, 0, 1)});
    rows.push_back('{CMD_ALLOC, 16'd0,     16'd0,     1, mk(ST_ZERO, 0, 1)});
    rows.push_back('{CMD_NOP,   16'hFFFF,  16'hFFFF,  1, mk(ST_OK, 0, 1)});
    rows.push_back('{CMD_FREE,  16'd0,     16'hFFFF,  1, mk(ST_OK, 0, 1)});
    rows.push_back('{CMD_ALLOC, 16'hFFFF,  16'd0,     1, mk(ST_OK, 0, 1)});
    rows.push_back('{CMD_ALLOC, 16'd1,     16'd0,     1, mk(ST_NOFIT, 0, 1)});
    rows.push_back('{CMD_FREE,  16'd0,     16'd0,     1, mk(ST_OK, 0, 1)});
    rows.push_back('{CMD_ALLOC, 16'd1,     16'd0,     1, mk(ST_OK, 0, 2)});
    rows.push_back('{CMD_ALLOC, 16'd7,     16'd0,     1, mk(ST_OK, 4, 3)});
    rows.push_back('{CMD_ALLOC, 16'd100,   16'd0,     0, '0});
    rows.push_back('{CMD_ALLOC, 16'd3,     16'd0,     0, '0});
    rows.push_back('{CMD_FREE,  16'd4,     16'd4,     0, '0});
    rows.push_back('{CMD_ALLOC, 16'd8,     16'd0,     0, '0});
    rows.push_back('{CMD_ALLOC, 16'd4,     16'd0,     0, '0});
    rows.push_back('{CMD_FREE,  16'd0,     16'd12,    0, '0});
    rows.push_back('{CMD_ALLOC, 16'h8000,  16'd0,     0, '0});
    rows.push_back('{CMD_ALLOC, 16'hFFFF,  16'd0,     0, '0});
    rows.push_back('{CMD_COUNT, 16'd0,     16'd0,     0, '0});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_request(rows[i].cmd, rows[i].req, rows[i].foff,
                                   rows[i].typed, rows[i].res);

    // Random phases, each under its own policy; phases 1 to 6 write the arena size, later ones at random.
    phase = 0;
    while (sent < 1050) begin
      write_reg(CFG_POLICY, 17'($urandom_range(3)));
      if (phase == 1) write_reg(CFG_ARENA, 17'd65536);
      else if (phase > 1 && phase < 7) write_reg(CFG_ARENA, arena_choices[phase - 1]);
      else if (phase >= 7 && $urandom_range(2) == 0) write_reg(CFG_ARENA, 17'($urandom));
      quiet = (sent > 450 && sent < 600);
      // The fill phase runs long enough to reach a full table.
      plen = (phase == 1) ? 80 : $urandom_range(40, 90);
      for (int n = 0; n < plen; n++) begin
        if (sent >= 1050) break;
        roll = $urandom_range(99);
        foff = 16'($urandom);
        req = 16'($urandom);
        if (phase == 1 || roll < 45) begin
          // Table fill on the second phase, small sizes elsewhere.
          cmd = CMD_ALLOC;
          req = (phase == 1) ? 16'($urandom_range(1, 6)) : 16'($urandom_range(1, 2048));
        end else if (roll < 50) begin
          cmd = CMD_ALLOC;
        end else if (roll < 78) begin
          cmd = CMD_FREE;
          foff = tbl_off[$urandom_range(tbl_total - 1)];
        end else if (roll < 83) begin
          cmd = CMD_FREE;
        end else if (roll < 91) begin
          cmd = CMD_COUNT;
        end else if (roll < 95) begin
          cmd = CMD_NOP;
        end else begin
          cmd = CMD_ALLOC;
          req = '0;
        end
        if (sent == 300) long_hold = 1'b1;
        send_request(cmd, req, foff, 1'b0, '0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/stalloc_pkg.sv
rtl/stalloc_cell.sv
rtl/segment_table_allocator_core.sv
sim/tb.sv
